// ===== rtl/core/sfdi_pkg.sv =====
// shared types, constants and register codes of the stereo feedback delay
package sfdi_pkg;

    localparam int DEPTH_DEF       = 131072;
    localparam int SAMPLE_BITS_DEF = 24;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 33;
    localparam int DELAY_W    = 33;
    localparam int MIX_W      = 17;
    localparam int GAIN_W     = 16;
    localparam int FRAC_W     = 16;

    localparam int SMOOTH_NUM_W = 11;
    localparam logic [SMOOTH_NUM_W-1:0] SMOOTH_NUM = 11'd1049;
    localparam int SMOOTH_SHIFT = 20;

    localparam logic [MIX_W-1:0]   MIX_ONE      = 17'd65536;
    localparam logic [MIX_W-1:0]   MIX_RESET    = 17'd32768;
    localparam logic [GAIN_W-1:0]  GAIN_RESET   = 16'd32768;
    localparam logic [DELAY_W-1:0] DELAY_RESET  = 33'd1572864000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIX    = 2'd0,
        REG_GAIN   = 2'd1,
        REG_TARGET = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic wr_en;
        logic clear;
        logic cap_q0;
        logic interp_en;
        logic mix_en;
    } lane_ctl_t;

endpackage

// ===== rtl/core/sfdi_in_if.sv =====
// input channel carrying one stereo frame per item
interface sfdi_in_if #(
    parameter int SAMPLE_BITS = sfdi_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink (input valid, input left_in, input right_in, output ready);
endinterface

// ===== rtl/core/sfdi_out_if.sv =====
// output channel carrying one mixed stereo frame per item
interface sfdi_out_if #(
    parameter int SAMPLE_BITS = sfdi_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink (input valid, input left_out, input right_out, output ready);
endinterface

// ===== rtl/core/sfdi_delay_mem.sv =====
// single-port-write, registered-read sample memory of one channel
module sfdi_delay_mem #(
    parameter int DEPTH = sfdi_pkg::DEPTH_DEF,
    parameter int WIDTH = sfdi_pkg::SAMPLE_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/sfdi_lane.sv =====
// one channel: delay store, tap interpolation, feedback and dry/wet mix
module sfdi_lane #(
    parameter int DEPTH       = sfdi_pkg::DEPTH_DEF,
    parameter int SAMPLE_BITS = sfdi_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sfdi_pkg::lane_ctl_t                 ctl,
    input  logic [$clog2(DEPTH)-1:0]            wr_addr,
    input  logic [$clog2(DEPTH)-1:0]            rd_addr,
    input  logic signed [SAMPLE_BITS-1:0]       x,
    input  logic [sfdi_pkg::FRAC_W-1:0]         frac,
    input  logic [sfdi_pkg::MIX_W-1:0]          mix,
    input  logic [sfdi_pkg::GAIN_W-1:0]         gain,
    output logic signed [SAMPLE_BITS-1:0]       mix_out
);
    localparam int S  = SAMPLE_BITS;
    localparam int FW = sfdi_pkg::FRAC_W;
    localparam logic signed [S-1:0] S_MAX = {1'b0, {(S-1){1'b1}}};
    localparam logic signed [S-1:0] S_MIN = {1'b1, {(S-1){1'b0}}};

    logic signed [S-1:0]  fb_reg;
    logic signed [S-1:0]  q0_reg;
    logic signed [S-1:0]  y_reg;
    logic [S-1:0]         rdata;
    logic signed [S:0]    store_sum;
    logic signed [S-1:0]  store_val;
    logic [S-1:0]         wdata;
    logic signed [S:0]    tap_diff;
    logic signed [S+FW+1:0] interp_prod;
    logic signed [S:0]    y_wide;
    logic signed [S+FW:0] fb_prod;
    logic signed [S:0]    mix_diff;
    logic signed [S+sfdi_pkg::MIX_W+1:0] mix_prod;
    logic signed [S:0]    mix_wide;

    // saturated write value, forced to zero during the clearing sweep
    always_comb
    begin
        store_sum = {x[S-1], x} + {fb_reg[S-1], fb_reg};
        if (store_sum[S] != store_sum[S-1])
        begin
            store_val = store_sum[S] ? S_MIN : S_MAX;
        end
        else
        begin
            store_val = store_sum[S-1:0];
        end
        wdata = ctl.clear ? '0 : store_val;
    end

    sfdi_delay_mem #(
        .DEPTH (DEPTH),
        .WIDTH (S)
    ) u_mem (
        .clk   (clk),
        .we    (ctl.wr_en),
        .waddr (wr_addr),
        .wdata (wdata),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    // y = x0 + floor((x1 - x0) * f / 2^16)
    always_comb
    begin
        tap_diff    = $signed({rdata[S-1], rdata}) - $signed({q0_reg[S-1], q0_reg});
        interp_prod = tap_diff * $signed({1'b0, frac});
        y_wide      = $signed({q0_reg[S-1], q0_reg}) + $signed(interp_prod[S+FW:FW]);
    end

    // feedback and crossfade from the registered delayed sample
    always_comb
    begin
        fb_prod  = y_reg * $signed({1'b0, gain});
        mix_diff = $signed({y_reg[S-1], y_reg}) - $signed({x[S-1], x});
        mix_prod = mix_diff * $signed({1'b0, mix});
        mix_wide = $signed({x[S-1], x}) + $signed(mix_prod[S+FW:FW]);
        mix_out  = $signed(mix_wide[S-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_reg <= '0;
        end
        else if (ctl.mix_en)
        begin
            fb_reg <= $signed(fb_prod[S+FW-1:FW]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.cap_q0)
        begin
            q0_reg <= $signed(rdata);
        end
        if (ctl.interp_en)
        begin
            y_reg <= $signed(y_wide[S-1:0]);
        end
    end
endmodule

// ===== rtl/core/stereo_feedback_delay_interp_top.sv =====
// top level: frame sequencer, delay smoothing, configuration and output register
//
// stereo feedback delay with a smoothly moving fractional tap
// in_ch takes one stereo frame per item (valid/ready), out_ch returns one
// mixed frame per item in the same order
// cfg_we/cfg_idx/cfg_wdata write the mix, feedback gain and delay target
// registers; writing the target also jumps the smoothed delay to it
// an item runs through the frame sequencer steps in order: the store
// write, the two tap reads of the single read port and the two multiply
// stages (interpolation, then mix), the mix step loading the output
// register; the next item is accepted only once the sequencer is back
// in idle, so items never overlap
// after reset the block sweeps both delay stores to zero, one entry per
// cycle, over all DELAY_DEPTH entries, with in_ch.ready low; configuration writes
// are taken during the sweep
// when out_ch stalls, the finished item waits in the output register and
// the following item runs up to its mix step and holds there
module stereo_feedback_delay_interp_top #(
    parameter int DELAY_DEPTH = sfdi_pkg::DEPTH_DEF,
    parameter int SAMPLE_BITS = sfdi_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [sfdi_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [sfdi_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    sfdi_in_if.sink                           in_ch,
    sfdi_out_if.source                        out_ch
);
    localparam int AW    = $clog2(DELAY_DEPTH);
    localparam int S     = SAMPLE_BITS;
    localparam int DW    = sfdi_pkg::DELAY_W;
    localparam int FW    = sfdi_pkg::FRAC_W;
    localparam int POS_W = AW + FW;
    localparam int WIDE_W = (POS_W > DW) ? POS_W : DW;
    localparam int PROD_W = DW + sfdi_pkg::SMOOTH_NUM_W;

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_STORE  = 7'b0000100,
        S_RD0    = 7'b0001000,
        S_RD1    = 7'b0010000,
        S_INTERP = 7'b0100000,
        S_MIX    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [AW-1:0]                 clr_addr_reg;
    logic [AW-1:0]                 wp_reg;
    logic [DW-1:0]                 smoothed_reg;
    logic [DW-1:0]                 target_reg;
    logic [sfdi_pkg::MIX_W-1:0]    mix_reg;
    logic [sfdi_pkg::GAIN_W-1:0]   gain_reg;
    logic [DW-1:0]                 mag_reg;
    logic                          neg_reg;
    logic signed [S-1:0]           xl_reg;
    logic signed [S-1:0]           xr_reg;
    logic                          out_valid_reg;
    logic signed [S-1:0]           left_out_reg;
    logic signed [S-1:0]           right_out_reg;

    logic                          in_acc;
    logic                          out_free;
    logic                          mix_go;
    logic [DW:0]                   delta;
    logic [DW-1:0]                 mag;
    logic [PROD_W-1:0]             step_prod;
    logic [DW-1:0]                 step;
    logic [WIDE_W-1:0]             pos_wide;
    logic [POS_W-1:0]              pos;
    logic [AW-1:0]                 i0;
    logic [AW-1:0]                 i1;
    logic [AW-1:0]                 rd_addr;
    logic [AW-1:0]                 wr_addr;
    logic [sfdi_pkg::MIX_W-1:0]    mix_eff;
    logic signed [S-1:0]           left_mix;
    logic signed [S-1:0]           right_mix;
    sfdi_pkg::lane_ctl_t           ctl;

    assign in_ch.ready      = (state_reg == S_IDLE);
    assign in_acc           = in_ch.valid && in_ch.ready;
    assign out_free         = !out_valid_reg || out_ch.ready;
    assign mix_go           = (state_reg == S_MIX) && out_free;
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.left_out  = left_out_reg;
    assign out_ch.right_out = right_out_reg;

    // smoothing step, tap position, memory addresses and clamped mix
    always_comb
    begin
        delta     = {1'b0, target_reg} - {1'b0, smoothed_reg};
        mag       = delta[DW] ? DW'(-delta) : delta[DW-1:0];
        step_prod = mag_reg * sfdi_pkg::SMOOTH_NUM;
        step      = DW'(step_prod >> sfdi_pkg::SMOOTH_SHIFT);
        pos_wide  = WIDE_W'({wp_reg, {FW{1'b0}}}) - WIDE_W'(smoothed_reg);
        pos       = pos_wide[POS_W-1:0];
        i0        = pos[POS_W-1:FW];
        i1        = i0 + AW'(1);
        rd_addr   = (state_reg == S_RD1) ? i1 : i0;
        wr_addr   = (state_reg == S_CLEAR) ? clr_addr_reg : wp_reg;
        mix_eff   = (mix_reg > sfdi_pkg::MIX_ONE) ? sfdi_pkg::MIX_ONE : mix_reg;
    end

    always_comb
    begin
        ctl.wr_en     = (state_reg == S_CLEAR) || (state_reg == S_STORE);
        ctl.clear     = (state_reg == S_CLEAR);
        ctl.cap_q0    = (state_reg == S_RD1);
        ctl.interp_en = (state_reg == S_INTERP);
        ctl.mix_en    = mix_go;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_addr_reg == AW'(DELAY_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_STORE;
                end
            end
            S_STORE:  state_next = S_RD0;
            S_RD0:    state_next = S_RD1;
            S_RD1:    state_next = S_INTERP;
            S_INTERP: state_next = S_MIX;
            S_MIX:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            wp_reg        <= '0;
            smoothed_reg  <= sfdi_pkg::DELAY_RESET;
            target_reg    <= sfdi_pkg::DELAY_RESET;
            mix_reg       <= sfdi_pkg::MIX_RESET;
            gain_reg      <= sfdi_pkg::GAIN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (state_reg == S_STORE)
            begin
                smoothed_reg <= neg_reg ? smoothed_reg - step : smoothed_reg + step;
            end
            if (mix_go)
            begin
                wp_reg        <= wp_reg + AW'(1);
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (sfdi_pkg::cfg_reg_t'(cfg_idx))
                    sfdi_pkg::REG_MIX:    mix_reg  <= cfg_wdata[sfdi_pkg::MIX_W-1:0];
                    sfdi_pkg::REG_GAIN:   gain_reg <= cfg_wdata[sfdi_pkg::GAIN_W-1:0];
                    sfdi_pkg::REG_TARGET:
                    begin
                        target_reg   <= cfg_wdata[DW-1:0];
                        smoothed_reg <= cfg_wdata[DW-1:0];
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            xl_reg  <= in_ch.left_in;
            xr_reg  <= in_ch.right_in;
            mag_reg <= mag;
            neg_reg <= delta[DW];
        end
        if (mix_go)
        begin
            left_out_reg  <= left_mix;
            right_out_reg <= right_mix;
        end
    end

    sfdi_lane #(
        .DEPTH       (DELAY_DEPTH),
        .SAMPLE_BITS (S)
    ) u_lane_l (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .x       (xl_reg),
        .frac    (pos[FW-1:0]),
        .mix     (mix_eff),
        .gain    (gain_reg),
        .mix_out (left_mix)
    );

    sfdi_lane #(
        .DEPTH       (DELAY_DEPTH),
        .SAMPLE_BITS (S)
    ) u_lane_r (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .x       (xr_reg),
        .frac    (pos[FW-1:0]),
        .mix     (mix_eff),
        .gain    (gain_reg),
        .mix_out (right_mix)
    );

    // an accepted item goes straight into its store step
    a_accept_store: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> state_reg == S_STORE)
        else $error("accepted item did not enter store step");

    // a result only appears from the mix step
    a_out_from_mix: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_MIX))
        else $error("result loaded outside mix step");

    // the write pointer moves by one per delivered frame
    a_wp_step: assert property (@(posedge clk) disable iff (!rst_n)
        mix_go |=> wp_reg == $past(wp_reg + AW'(1)))
        else $error("write pointer did not advance");

    // the clearing sweep ends only after the last entry
    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && $past(state_reg == S_CLEAR))
        |-> $past(clr_addr_reg) == AW'(DELAY_DEPTH - 1))
        else $error("clearing sweep ended early");
endmodule

// ===== tb/tb_stereo_feedback_delay_interp_top.sv =====
// self-checking testbench for the stereo feedback delay against a bit-exact echo predictor
module tb_stereo_feedback_delay_interp_top;

    localparam int DEPTH         = sfdi_pkg::DEPTH_DEF;
    localparam int SB            = sfdi_pkg::SAMPLE_BITS_DEF;
    localparam int PTR_W         = $clog2(DEPTH);
    localparam int CFG_IDX_W     = sfdi_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W    = sfdi_pkg::CFG_DATA_W;
    localparam int DELAY_W       = sfdi_pkg::DELAY_W;
    localparam int MIX_W         = sfdi_pkg::MIX_W;
    localparam int GAIN_W        = sfdi_pkg::GAIN_W;
    localparam int FRAC_W        = sfdi_pkg::FRAC_W;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_REPORTS   = 10;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE        = 2'd3;
    localparam logic signed [SB-1:0] S_MAX            = 24'sh7FFFFF;
    localparam logic signed [SB-1:0] S_MIN            = 24'sh800000;
    localparam logic [DELAY_W-1:0]   DELAY_TOP        = 33'h1_FFFF_FFFF;
    localparam logic [DELAY_W-1:0]   DELAY_LAST_WHOLE = 33'h1_FFFF_0000;
    localparam logic [DELAY_W-1:0]   DELAY_ONE_HALF   = 33'd98304;
    localparam logic [MIX_W-1:0]     MIX_TOP          = 17'h1FFFF;
    localparam logic [GAIN_W-1:0]    GAIN_MAX_RANGE   = 16'd64225;
    localparam logic [GAIN_W-1:0]    GAIN_TOP         = 16'hFFFF;

    typedef struct packed {
        logic signed [SB-1:0] left;
        logic signed [SB-1:0] right;
    } frame_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    sfdi_in_if  #(.SAMPLE_BITS(SB)) in_ch ();
    sfdi_out_if #(.SAMPLE_BITS(SB)) out_ch ();

    stereo_feedback_delay_interp_top #(
        .DELAY_DEPTH(DEPTH),
        .SAMPLE_BITS(SB)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_wdata(cfg_wdata),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    frame_t               frames_due[$];
    logic signed [SB-1:0] echo_mem [2][DEPTH];
    longint               echo_fb [2];
    logic [PTR_W-1:0]     wr_ptr;
    logic [DELAY_W-1:0]   delay_goal;
    logic [DELAY_W-1:0]   delay_now;
    longint               mix_q16;
    longint               gain_q16;

    int idle_pct   = 0;
    int stall_pct  = 0;
    int hold_left  = 0;
    int mismatches = 0;
    int cycle_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("stereo_feedback_delay_interp_top regression: fail");
        $finish;
    end

    // receiver: long hold-off first, random stall otherwise
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ch.ready = 1'b0;
                hold_left--;
            end
            else
            begin
                out_ch.ready = ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        frame_t due;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (frames_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected frame left %0d right %0d", out_ch.left_out,
                             out_ch.right_out);
            end
            else
            begin
                due = frames_due.pop_front();
                if (due.left !== out_ch.left_out || due.right !== out_ch.right_out)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("frame mismatch: left exp %0d got %0d, right exp %0d got %0d",
                                 due.left, out_ch.left_out, due.right, out_ch.right_out);
                end
            end
        end
    end

    task automatic reset_model();
        for (int i = 0; i < DEPTH; i++)
        begin
            echo_mem[0][i] = '0;
            echo_mem[1][i] = '0;
        end
        echo_fb[0] = 0;
        echo_fb[1] = 0;
        wr_ptr     = '0;
        delay_goal = sfdi_pkg::DELAY_RESET;
        delay_now  = sfdi_pkg::DELAY_RESET;
        mix_q16    = longint'(sfdi_pkg::MIX_RESET);
        gain_q16   = longint'(sfdi_pkg::GAIN_RESET);
    endtask

    // one frame of the echo: smooth the delay, write, interpolate two taps, feed back, mix
    function automatic void predict_frame(input logic signed [SB-1:0] l,
                                          input logic signed [SB-1:0] r);
        longint             diff;
        longint             mag;
        longint             stepv;
        longint             x;
        longint             y;
        longint             sum;
        longint             frac;
        longint             wet;
        longint             acc;
        logic [DELAY_W-1:0] pos;
        logic [PTR_W-1:0]   i0;
        logic [PTR_W-1:0]   i1;
        frame_t             due;
        int                 ch;
        diff  = longint'(delay_goal) - longint'(delay_now);
        mag   = (diff < 0) ? -diff : diff;
        stepv = (mag * longint'(sfdi_pkg::SMOOTH_NUM)) >>> sfdi_pkg::SMOOTH_SHIFT;
        if (diff < 0)
            delay_now = delay_now - DELAY_W'(stepv);
        else
            delay_now = delay_now + DELAY_W'(stepv);
        pos  = {wr_ptr, {FRAC_W{1'b0}}} - delay_now;
        i0   = pos[DELAY_W-1:FRAC_W];
        i1   = i0 + 1'b1;
        frac = longint'(pos[FRAC_W-1:0]);
        wet  = (mix_q16 > 65536) ? 65536 : mix_q16;
        for (ch = 0; ch < 2; ch++)
        begin
            if (ch == 0)
                x = l;
            else
                x = r;
            sum = x + echo_fb[ch];
            if (sum > S_MAX)
                sum = S_MAX;
            else if (sum < S_MIN)
                sum = S_MIN;
            echo_mem[ch][wr_ptr] = sum[SB-1:0];
            y = (longint'(echo_mem[ch][i0]) * (65536 - frac)
                 + longint'(echo_mem[ch][i1]) * frac) >>> 16;
            echo_fb[ch] = (y * gain_q16) >>> 16;
            acc = (x * (65536 - wet) + y * wet) >>> 16;
            if (ch == 0)
                due.left = acc[SB-1:0];
            else
                due.right = acc[SB-1:0];
        end
        wr_ptr = wr_ptr + 1'b1;
        frames_due.push_back(due);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_idx   = idx;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            sfdi_pkg::REG_MIX:    mix_q16 = longint'(value[MIX_W-1:0]);
            sfdi_pkg::REG_GAIN:   gain_q16 = longint'(value[GAIN_W-1:0]);
            sfdi_pkg::REG_TARGET:
            begin
                delay_goal = value[DELAY_W-1:0];
                delay_now  = value[DELAY_W-1:0];
            end
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [MIX_W-1:0] mix,
                                  input logic [GAIN_W-1:0] gain,
                                  input logic [DELAY_W-1:0] delay);
        write_reg(sfdi_pkg::REG_MIX, CFG_DATA_W'(mix));
        write_reg(sfdi_pkg::REG_GAIN, CFG_DATA_W'(gain));
        write_reg(sfdi_pkg::REG_TARGET, CFG_DATA_W'(delay));
    endtask

    task automatic send_frame(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid    = 1'b1;
        in_ch.left_in  = l;
        in_ch.right_in = r;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_frame(l, r);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic signed [SB-1:0] pick_sample();
        logic [31:0] raw;
        raw = $urandom();
        case ($urandom_range(9))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return {{(SB-12){raw[11]}}, raw[11:0]};
            default: return raw[SB-1:0];
        endcase
    endfunction

    function automatic logic [DELAY_W-1:0] pick_delay();
        logic [DELAY_W-1:0] v;
        v = '0;
        case ($urandom_range(9))
            0: v = '0;
            1: v = DELAY_LAST_WHOLE;
            2: v = DELAY_TOP;
            3:
            begin
                v[31:0] = $urandom();
                v[32]   = $urandom_range(1);
            end
            default: v[31:0] = $urandom_range(500 * 65536);
        endcase
        return v;
    endfunction

    function automatic logic [MIX_W-1:0] pick_mix();
        case ($urandom_range(5))
            0:       return '0;
            1:       return sfdi_pkg::MIX_ONE;
            2:       return MIX_W'($urandom_range(131071));
            default: return MIX_W'($urandom_range(65536));
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(5))
            0:       return '0;
            1:       return GAIN_MAX_RANGE;
            2:       return GAIN_TOP;
            default: return GAIN_W'($urandom_range(64225));
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_frame(S_MAX, S_MIN);
        send_frame(S_MIN, S_MAX);
        send_frame(pick_sample(), pick_sample());
    endtask

    task automatic test_directed_cases();
        // zero delay, fully wet: reads the sample just written
        drain_results();
        apply_settings(sfdi_pkg::MIX_ONE, '0, '0);
        send_frame(S_MAX, S_MIN);
        send_frame(S_MIN, S_MAX);
        send_frame('0, -24'sd1);
        send_frame(24'sd1, '0);
        // mix above unity, strong feedback into saturation, ignored spare register
        drain_results();
        apply_settings(MIX_TOP, GAIN_MAX_RANGE, '0);
        write_reg(REG_SPARE, '0);
        send_frame(S_MAX, S_MIN);
        send_frame(S_MAX, S_MIN);
        send_frame(S_MAX, S_MIN);
        send_frame(S_MIN, S_MAX);
        // fractional delay between two taps
        drain_results();
        apply_settings(sfdi_pkg::MIX_ONE, GAIN_TOP, DELAY_ONE_HALF);
        repeat (4) send_frame(pick_sample(), pick_sample());
        // largest delay, just under the store length
        drain_results();
        apply_settings(sfdi_pkg::MIX_ONE, sfdi_pkg::GAIN_RESET, DELAY_TOP);
        repeat (3) send_frame(pick_sample(), pick_sample());
        drain_results();
        apply_settings(17'd1, 16'd1, 33'd65536);
        send_frame(S_MAX, S_MAX);
        send_frame(S_MIN, S_MIN);
    endtask

    task automatic test_random_traffic();
        int idle_set [4];
        int stall_set [4];
        idle_set  = '{0, 48, 0, 19};
        stall_set = '{0, 0, 48, 19};
        for (int p = 0; p < 4; p++)
        begin
            for (int h = 0; h < 2; h++)
            begin
                drain_results();
                idle_pct  = idle_set[p];
                stall_pct = stall_set[p];
                apply_settings(pick_mix(), pick_gain(), pick_delay());
                repeat (70) send_frame(pick_sample(), pick_sample());
            end
        end
    endtask

    task automatic test_output_hold();
        drain_results();
        idle_pct  = 0;
        stall_pct = 0;
        apply_settings(pick_mix(), pick_gain(), 33'd3 * 33'd65536 + 33'd12345);
        @(posedge clk);
        hold_left = HOLD_CYCLES;
        repeat (16) send_frame(pick_sample(), pick_sample());
        // sender waits for every result before going on
        drain_results();
        idle_pct  = 19;
        stall_pct = 19;
        repeat (8) send_frame(pick_sample(), pick_sample());
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = sfdi_pkg::REG_MIX;
        cfg_wdata      = '0;
        in_ch.valid    = 1'b0;
        in_ch.left_in  = '0;
        in_ch.right_in = '0;
        reset_model();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_directed_cases();
        test_random_traffic();
        test_output_hold();

        drain_results();
        mismatches += frames_due.size();
        if (mismatches == 0)
            $display("stereo_feedback_delay_interp_top regression: pass");
        else
            $display("stereo_feedback_delay_interp_top regression: fail");
        $finish;
    end

endmodule
